// ===== rtl/mrgs_pkg.sv =====
package mrgs_pkg;

    localparam int MAX_ITEMS_DEF   = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the incoming word into the sorted row
        logic shift;    // move every word one cell toward the head
    } cell_ctrl_t;

endpackage

// ===== rtl/mrgs_cell.sv =====
module mrgs_cell #(
    parameter int VALUE_WIDTH = mrgs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrgs_pkg::cell_ctrl_t          ctrl,
    input  logic signed [VALUE_WIDTH-1:0] new_value,
    input  logic                          prev_take,
    input  logic                          prev_valid,
    input  logic signed [VALUE_WIDTH-1:0] prev_value,
    input  logic                          next_valid,
    input  logic signed [VALUE_WIDTH-1:0] next_value,
    output logic                          take,
    output logic                          valid,
    output logic signed [VALUE_WIDTH-1:0] value
);
    import mrgs_pkg::*;

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic signed [VALUE_WIDTH-1:0] value_next;

    // Strictly greater: an equal incoming word lands behind the held one
    assign take = !valid_reg || (value_reg > new_value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.insert)
        begin
            valid_next = valid_reg || prev_valid;
            if (take)
            begin
                value_next = prev_take ? prev_value : new_value;
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = next_valid;
            value_next = next_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

// ===== rtl/merge_sorter_top.sv =====
// Streaming sorter for batches of signed words. Words enter one per cycle on the
// input channel while the row is loading; the word with final_item set closes the
// batch. Up to MAX_ITEMS words are kept in a row of compare-and-shift cells that
// stays sorted at all times: each incoming word is inserted in the cycle it is
// accepted. Words arriving while the row is full are dropped and the batch is
// flagged (overflowed set on every output word of that batch). After the final
// word the row drains from its head, one word per cycle while the sink accepts,
// smallest first; last_of_run marks the greatest word. The input is stalled while
// the row drains, so the next batch cannot be taken until the last word has left.
// Equal words keep their arrival order. The output word comes straight from the
// head cell's register.
module merge_sorter_top #(
    parameter int MAX_ITEMS   = mrgs_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = mrgs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VALUE_WIDTH-1:0] item_value,
    input  logic                          final_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0] sorted_value,
    output logic                          last_of_run,
    output logic                          overflowed
);
    import mrgs_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;

    logic              in_fire;
    logic              out_fire;
    logic              room;
    cell_ctrl_t        ctrl;

    // Chain wiring, one slot per cell
    logic                          take_w  [MAX_ITEMS];
    logic                          valid_w [MAX_ITEMS];
    logic signed [VALUE_WIDTH-1:0] value_w [MAX_ITEMS];

    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign out_valid = (state_reg == ST_DRAIN);
    assign out_fire  = out_valid && out_ready;
    assign room      = (count_reg != CNT_FULL);

    assign ctrl.insert = in_fire && room;
    assign ctrl.shift  = out_fire;

    // Head cell has no left neighbor; tail cell has an empty right neighbor
    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            logic                          p_take;
            logic                          p_valid;
            logic signed [VALUE_WIDTH-1:0] p_value;
            logic                          n_valid;
            logic signed [VALUE_WIDTH-1:0] n_value;

            if (gi == 0)
            begin : g_head
                assign p_take  = 1'b0;
                assign p_valid = 1'b1;
                assign p_value = item_value;
            end
            else
            begin : g_body
                assign p_take  = take_w[gi-1];
                assign p_valid = valid_w[gi-1];
                assign p_value = value_w[gi-1];
            end

            if (gi == MAX_ITEMS - 1)
            begin : g_tail
                assign n_valid = 1'b0;
                assign n_value = '0;
            end
            else
            begin : g_mid
                assign n_valid = valid_w[gi+1];
                assign n_value = value_w[gi+1];
            end

            mrgs_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_value  (item_value),
                .prev_take  (p_take),
                .prev_valid (p_valid),
                .prev_value (p_value),
                .next_valid (n_valid),
                .next_value (n_value),
                .take       (take_w[gi]),
                .valid      (valid_w[gi]),
                .value      (value_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (room)
                    begin
                        count_next = count_reg + CNT_ONE;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (final_item)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_fire)
                begin
                    count_next = count_reg - CNT_ONE;
                    if (count_reg == CNT_ONE)
                    begin
                        // run complete: batch state back to empty
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign sorted_value = value_w[0];
    assign last_of_run  = (count_reg == CNT_ONE);
    assign overflowed   = ovf_reg;

endmodule

// ===== tb/merge_sorter_top_test.sv =====
`timescale 1ns / 100ps

// Checks merge_sorter_top against a sorted-row prediction kept in the bench.
// Words go in as batches closed by final_item; each batch comes back smallest
// first with last_of_run on its greatest word and overflowed set when the
// batch lost words to a full store.
module merge_sorter_top_test;

    localparam int CAPACITY     = mrgs_pkg::MAX_ITEMS_DEF;
    localparam int VW           = mrgs_pkg::VALUE_WIDTH_DEF;
    localparam int RANDOM_WORDS = 80;
    localparam int HOLD_CYCLES  = 400;              // long sink hold-off
    localparam int CYCLE_LIMIT  = 250000;           // watchdog
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 32; // quiet time at the end
    localparam int MAX_REPORTS  = 10;

    typedef logic signed [VW-1:0] word_t;

    // One expected output word
    typedef struct {
        word_t value;
        logic  last;
        logic  ovf;
    } sorted_word_t;

    // Sink ready patterns
    typedef enum logic [1:0] {
        SINK_STEADY,    // always ready
        SINK_MOSTLY,    // ready unless a random pick in 0..3 is zero
        SINK_SPARSE,    // ready only when a random pick in 0..3 is zero
        SINK_TOGGLE     // ready inverted on every clock
    } sink_mode_t;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  in_valid   = 1'b0;
    logic  in_ready;
    word_t item_value = '0;
    logic  final_item = 1'b0;
    logic  out_valid;
    logic  out_ready  = 1'b0;
    word_t sorted_value;
    logic  last_of_run;
    logic  overflowed;

    // Prediction state: the kept words of the open batch, held in sorted order
    word_t        batch_row[$];
    logic         batch_ovf = 1'b0;
    sorted_word_t expected_words[$];

    // Sender burst state
    int   burst_left = 0;
    logic no_idle    = 1'b0;

    // Sink state
    sink_mode_t sink_mode = SINK_STEADY;
    int         mode_left = 0;
    logic       hold_on   = 1'b0;
    event       hold_go;

    int errors      = 0;
    int cycle_count = 0;

    merge_sorter_top #(
        .MAX_ITEMS  (CAPACITY),
        .VALUE_WIDTH(VW)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .item_value  (item_value),
        .final_item  (final_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sorted_value(sorted_value),
        .last_of_run (last_of_run),
        .overflowed  (overflowed)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Sink: switches between ready patterns at random intervals;
    // a hold-off request overrides the pattern.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            mode_left <= $urandom_range(16, 96);
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
        end
        else
        begin
            mode_left <= mode_left - 1;
        end

        if (hold_on)
            out_ready <= 1'b0;
        else
        begin
            case (sink_mode)
                SINK_STEADY: out_ready <= 1'b1;
                SINK_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                SINK_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:     out_ready <= ~out_ready;
            endcase
        end
    end

    // Long hold-off, counted here so the sender keeps offering words meanwhile
    initial
    begin
        forever
        begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // Output check: every accepted word against the oldest expectation
    always @(posedge clk)
    begin
        sorted_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                errors <= errors + 1;
                if (errors < MAX_REPORTS)
                    $display("unexpected word: value %0d last %0b ovf %0b",
                             sorted_value, last_of_run, overflowed);
            end
            else
            begin
                want = expected_words.pop_front();
                if (sorted_value !== want.value || last_of_run !== want.last ||
                    overflowed !== want.ovf)
                begin
                    errors <= errors + 1;
                    if (errors < MAX_REPORTS)
                        $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 want.value, want.last, want.ovf,
                                 sorted_value, last_of_run, overflowed);
                end
            end
        end
    end

    // Prediction for one accepted word. Inserting after every kept word that
    // is not greater keeps ties in arrival order.
    task automatic predict_word(input word_t v, input logic fin);
        int           pos;
        int           k;
        sorted_word_t w;
        if (batch_row.size() < CAPACITY)
        begin
            pos = 0;
            while (pos < batch_row.size() && batch_row[pos] <= v)
                pos++;
            batch_row.insert(pos, v);
        end
        else
        begin
            batch_ovf = 1'b1;   // store full: word dropped
        end
        if (fin)
        begin
            for (k = 0; k < batch_row.size(); k++)
            begin
                w.value = batch_row[k];
                w.last  = (k == batch_row.size() - 1);
                w.ovf   = batch_ovf;
                expected_words.push_back(w);
            end
            batch_row.delete();
            batch_ovf = 1'b0;
        end
    endtask

    // Offer one word and wait for it to be taken. Bursts of random length
    // with random gaps between them unless no_idle is set.
    task automatic send_word(input word_t v, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        item_value <= v;
        final_item <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        predict_word(v, fin);
    endtask

    // Random word, weighted toward extremes and a narrow range for ties
    function automatic word_t pick_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(VW-1){1'b0}}};
            1:       return {1'b0, {(VW-1){1'b1}}};
            2, 3:    return word_t'(int'($urandom_range(0, 8)) - 4);
            4:       return word_t'($urandom_range(0, 1)) - word_t'(1);
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic send_batch(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_word(pick_value(), k == n - 1);
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0 || hold_on)
            @(posedge clk);
    endtask

    // One-word batches: both extremes and zero
    task automatic test_single_words();
        send_word({1'b1, {(VW-1){1'b0}}}, 1'b1);
        send_word({1'b0, {(VW-1){1'b1}}}, 1'b1);
        send_word('0, 1'b1);
    endtask

    // Mixed-sign batch with both extremes twice
    task automatic test_extremes();
        send_word({1'b0, {(VW-1){1'b1}}}, 1'b0);
        send_word({1'b1, {(VW-1){1'b0}}}, 1'b0);
        send_word('0, 1'b0);
        send_word('1, 1'b0);
        send_word(word_t'(1), 1'b0);
        send_word(word_t'(5), 1'b0);
        send_word(word_t'(5), 1'b0);
        send_word(-word_t'(5), 1'b0);
        send_word({1'b1, {(VW-1){1'b0}}}, 1'b0);
        send_word({1'b0, {(VW-1){1'b1}}}, 1'b1);
    endtask

    // All-equal batch, then a descending one
    task automatic test_ties();
        send_word(word_t'(7), 1'b0);
        send_word(word_t'(7), 1'b0);
        send_word(word_t'(7), 1'b1);
        send_word(word_t'(3), 1'b0);
        send_word(word_t'(2), 1'b0);
        send_word(-word_t'(2), 1'b1);
    endtask

    // Exactly full store: no overflow
    task automatic test_full_store();
        send_batch(CAPACITY);
    endtask

    // Final word arriving on a full store, then a batch well past capacity
    task automatic test_overflow();
        send_batch(CAPACITY + 1);
        send_batch(CAPACITY + 6);
    endtask

    // Sink holds off during a drain while the next batch is offered, so the
    // input stalls behind the stuck run.
    task automatic test_back_pressure();
        no_idle = 1'b1;
        send_batch(48);
        -> hold_go;
        send_batch(20);
        no_idle = 1'b0;
        // last word already taken: stop offering it while the run drains
        in_valid <= 1'b0;
        wait_drained();
    endtask

    // Random batches: mostly short, some large, a few overflowing
    task automatic test_random_batches();
        int sent;
        int n;
        int pick;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                n = $urandom_range(CAPACITY + 1, CAPACITY + 8);
            else if (pick <= 2)
                n = $urandom_range(CAPACITY / 2, CAPACITY);
            else
                n = $urandom_range(1, 12);
            no_idle = ($urandom_range(0, 4) == 0);
            send_batch(n);
            sent += n;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        // hold reset, then release it on a rising edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_words();
        test_extremes();
        test_ties();
        test_full_store();
        test_overflow();
        test_back_pressure();
        test_random_batches();

        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
